// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_NEVER(label, clk, rst, expr, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/bfd_pkg.sv =====
// ----------------------------------------------------------------------------
// bfd_pkg
// Types and fixed constants of the box filter downsampler.
// ----------------------------------------------------------------------------
package bfd_pkg;

  localparam int H_W          = 13;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int CW           = 14;
  localparam int OUT_DIM_W    = 11;
  localparam int CFG_INDEX_W  = 1;
  localparam int CFG_DATA_W   = 13;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SOURCE_WIDTH  = 1'b0,
    REG_SOURCE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [7:0] chan_t;
  typedef chan_t [3:0] rgba_t;

  typedef struct packed {
    logic emit;
    logic first;
    logic frame_last;
  } pix_ctl_t;

  typedef struct packed {
    rgba_t avg;
    logic  frame_last;
  } result_t;

endpackage

// ===== rtl/bfd_pixel_if.sv =====
// ----------------------------------------------------------------------------
// bfd_pixel_if
// Source pixel channel: one RGBA8 word per handshake.
// ----------------------------------------------------------------------------
interface bfd_pixel_if;
  logic          valid;
  logic          ready;
  bfd_pkg::chan_t in_red;
  bfd_pkg::chan_t in_green;
  bfd_pkg::chan_t in_blue;
  bfd_pkg::chan_t in_alpha;

  modport source (output valid, output in_red, output in_green, output in_blue,
                  output in_alpha, input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue,
                input in_alpha, output ready);
endinterface

// ===== rtl/bfd_result_if.sv =====
// ----------------------------------------------------------------------------
// bfd_result_if
// Output pixel channel: one averaged block word per handshake.
// ----------------------------------------------------------------------------
interface bfd_result_if;
  logic                             valid;
  logic                             ready;
  bfd_pkg::chan_t                   out_red;
  bfd_pkg::chan_t                   out_green;
  bfd_pkg::chan_t                   out_blue;
  bfd_pkg::chan_t                   out_alpha;
  logic                             frame_last;
  logic [bfd_pkg::OUT_DIM_W-1:0]    out_width;
  logic [bfd_pkg::OUT_DIM_W-1:0]    out_height;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output out_alpha, output frame_last, output out_width,
                  output out_height, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input out_alpha, input frame_last, input out_width,
                input out_height, output ready);
endinterface

// ===== rtl/bfd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bfd_cfg_if
// Configuration write channel: register index and data per word.
// ----------------------------------------------------------------------------
interface bfd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bfd_pkg::CFG_INDEX_W-1:0]    index;
  logic [bfd_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bfd_config.sv =====
// ----------------------------------------------------------------------------
// bfd_config
// Size registers; stores clamped source sizes and the output grid size.
// ----------------------------------------------------------------------------
module bfd_config #(
  parameter int FACTOR    = 4,
  parameter int MAX_WIDTH = 4096
) (
  input  logic                      clk,
  input  logic                      rst,
  bfd_cfg_if.sink                   cfg,
  output logic [$clog2(MAX_WIDTH+1)-1:0] w,
  output logic [bfd_pkg::H_W-1:0]   h,
  output logic [$clog2(MAX_WIDTH+1)-1:0] ow,
  output logic [bfd_pkg::H_W-1:0]   oh
);

  localparam int W_W = $clog2(MAX_WIDTH + 1);
  localparam int H_W = bfd_pkg::H_W;
  localparam int KR  = 20;
  localparam logic [KR-1:0] MR = KR'(((64'd1 << KR) + 64'(FACTOR) - 64'd1) / 64'(FACTOR));
  localparam int RESET_W = (bfd_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                               : bfd_pkg::RESET_WIDTH;
  localparam int RESET_H = bfd_pkg::RESET_HEIGHT;

  logic [W_W-1:0]    w_eff;
  logic [H_W-1:0]    h_eff;
  logic [W_W+KR-1:0] prod_w;
  logic [H_W+KR-1:0] prod_h;

  assign cfg.ready = 1'b1;

  always_comb begin
    if (cfg.data == '0) begin
      w_eff = W_W'(1);
    end else if (int'(cfg.data) > MAX_WIDTH) begin
      w_eff = W_W'(MAX_WIDTH);
    end else begin
      w_eff = W_W'(cfg.data);
    end
    if (cfg.data == '0) begin
      h_eff = H_W'(1);
    end else if (int'(cfg.data) > bfd_pkg::HEIGHT_LIMIT) begin
      h_eff = H_W'(bfd_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = H_W'(cfg.data);
    end
    prod_w = (W_W+KR)'(w_eff) * (W_W+KR)'(MR);
    prod_h = (H_W+KR)'(h_eff) * (H_W+KR)'(MR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w  <= W_W'(RESET_W);
      ow <= W_W'(RESET_W / FACTOR);
      h  <= H_W'(RESET_H);
      oh <= H_W'(RESET_H / FACTOR);
    end else if (cfg.valid) begin
      case (cfg.index)
        bfd_pkg::REG_SOURCE_WIDTH: begin
          w  <= w_eff;
          ow <= prod_w[KR +: W_W];
        end
        bfd_pkg::REG_SOURCE_HEIGHT: begin
          h  <= h_eff;
          oh <= prod_h[KR +: H_W];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/bfd_position.sv =====
// ----------------------------------------------------------------------------
// bfd_position
// Raster position counters; classifies each pixel against the block grid.
// ----------------------------------------------------------------------------
module bfd_position #(
  parameter int FACTOR    = 4,
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       accept,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]             w,
  input  logic [bfd_pkg::H_W-1:0]                    h,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]             ow,
  input  logic [bfd_pkg::H_W-1:0]                    oh,
  output logic                                       hit,
  output bfd_pkg::pix_ctl_t                          ctl,
  output logic [$clog2(MAX_WIDTH/FACTOR)-1:0]        addr
);

  localparam int ADDR_W = $clog2(MAX_WIDTH / FACTOR);
  localparam int PH_W   = $clog2(FACTOR);
  localparam int CW     = bfd_pkg::CW;
  localparam logic [PH_W-1:0] PH_LAST = PH_W'(FACTOR - 1);

  logic [11:0]     cc, rc, bc, br;
  logic [PH_W-1:0] px, py;
  logic [11:0]     cc_inc, rc_inc;
  logic            col_wrap, row_wrap;

  always_comb begin
    cc_inc         = cc + 12'd1;
    rc_inc         = rc + 12'd1;
    col_wrap       = (cc_inc == '0) || (CW'(cc_inc) >= CW'(w));
    row_wrap       = (rc_inc == '0) || (CW'(rc_inc) >= CW'(h));
    hit            = (CW'(bc) < CW'(ow)) && (CW'(br) < CW'(oh));
    ctl.first      = (px == '0) && (py == '0);
    ctl.emit       = hit && (px == PH_LAST) && (py == PH_LAST);
    ctl.frame_last = (CW'(bc) == CW'(ow) - CW'(1)) && (CW'(br) == CW'(oh) - CW'(1));
    addr           = bc[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cc <= '0;
      px <= '0;
      bc <= '0;
      rc <= '0;
      py <= '0;
      br <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        cc <= '0;
        px <= '0;
        bc <= '0;
        if (row_wrap) begin
          rc <= '0;
          py <= '0;
          br <= '0;
        end else begin
          rc <= rc_inc;
          if (py == PH_LAST) begin
            py <= '0;
            br <= br + 12'd1;
          end else begin
            py <= py + PH_W'(1);
          end
        end
      end else begin
        cc <= cc_inc;
        if (px == PH_LAST) begin
          px <= '0;
          bc <= bc + 12'd1;
        end else begin
          px <= px + PH_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/bfd_accum.sv =====
// ----------------------------------------------------------------------------
// bfd_accum
// Column sum line store with read-modify-write and the averaging stage.
// ----------------------------------------------------------------------------
module bfd_accum #(
  parameter int FACTOR    = 4,
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  bfd_pkg::pix_ctl_t                   ctl,
  input  logic [$clog2(MAX_WIDTH/FACTOR)-1:0] addr,
  input  bfd_pkg::rgba_t                      pix,
  output logic                                push,
  output bfd_pkg::result_t                    push_data,
  output logic [1:0]                          pending
);

  localparam int STORE_DEPTH = MAX_WIDTH / FACTOR;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int SUM_W       = 8 + 2 * $clog2(FACTOR);
  localparam int D           = FACTOR * FACTOR;
  localparam int KD          = SUM_W + 8;
  localparam int PR_W        = SUM_W + KD;
  localparam logic [KD-1:0] MD = KD'(((64'd1 << KD) + 64'(D) - 64'd1) / 64'(D));

  typedef logic [3:0][SUM_W-1:0] sums_t;
  typedef logic [3:0][PR_W-1:0]  prods_t;

  sums_t mem [STORE_DEPTH];
  sums_t rd;

  logic              s1_valid;
  bfd_pkg::pix_ctl_t s1_ctl;
  logic [ADDR_W-1:0] s1_addr;
  bfd_pkg::rgba_t    s1_pix;

  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;
  sums_t             fwd_data;

  sums_t  base, sum;
  logic   s2_valid, s2_last;
  sums_t  s2_sum;
  logic   s3_valid, s3_last;
  prods_t s3_prod;

  always_comb begin
    base = (fwd_valid && fwd_addr == s1_addr) ? fwd_data : rd;
    for (int c = 0; c < 4; c++) begin
      sum[c] = s1_ctl.first ? SUM_W'(s1_pix[c]) : base[c] + SUM_W'(s1_pix[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd <= mem[addr];
    end
    if (s1_valid) begin
      mem[s1_addr] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
    end else begin
      s1_valid  <= accept;
      fwd_valid <= s1_valid;
      s2_valid  <= s1_valid && s1_ctl.emit;
      s3_valid  <= s2_valid;
    end
    s1_ctl   <= ctl;
    s1_addr  <= addr;
    s1_pix   <= pix;
    fwd_addr <= s1_addr;
    fwd_data <= sum;
    s2_last  <= s1_ctl.frame_last;
    s2_sum   <= sum;
    s3_last  <= s2_last;
    for (int c = 0; c < 4; c++) begin
      s3_prod[c] <= PR_W'(s2_sum[c]) * PR_W'(MD);
    end
  end

  always_comb begin
    push                 = s3_valid;
    push_data.frame_last = s3_last;
    for (int c = 0; c < 4; c++) begin
      push_data.avg[c] = s3_prod[c][KD +: 8];
    end
    pending = 2'(s1_valid && s1_ctl.emit) + 2'(s2_valid) + 2'(s3_valid);
  end

endmodule

// ===== rtl/bfd_out_fifo.sv =====
// ----------------------------------------------------------------------------
// bfd_out_fifo
// Small result queue that decouples the pipeline from output stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfd_out_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  bfd_pkg::result_t           push_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bfd_pkg::result_t           out_data,
  output logic [bfd_pkg::CNT_W-1:0]  count
);

  localparam int DEPTH = bfd_pkg::FIFO_DEPTH;
  localparam int PTR_W = bfd_pkg::PTR_W;
  localparam int CNT_W = bfd_pkg::CNT_W;

  bfd_pkg::result_t q [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic             pop;

  assign out_valid = (count != '0);
  assign out_data  = q[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `ASSERT_IMPLIES(a_push_has_room, clk, rst, push, count < CNT_W'(DEPTH), "push into full queue")
  `ASSERT_NEVER(a_count_bound, clk, rst, count > CNT_W'(DEPTH), "queue count above depth")
  `ASSERT_NEXT(a_pop_drains, clk, rst, pop && !push, count == $past(count) - CNT_W'(1), "pop lost")

endmodule

// ===== rtl/box_filter_downsampler_top.sv =====
// ----------------------------------------------------------------------------
// box_filter_downsampler_top
// Result path: the pixel that closes a block passes registers s1, s2, s3 and then the output queue.
// Throughput: one pixel per clock; input holds off only while four results are
// in the pipeline or waiting in the output queue.
// Reset: synchronous; counters return to the frame origin, sizes to 640 by 480.
// The line store has no reset; each block's first pixel overwrites its entry, ignoring the stored value.
// ----------------------------------------------------------------------------
module box_filter_downsampler_top #(
  parameter int FACTOR    = 4,
  parameter int MAX_WIDTH = 4096
) (
  input  logic          clk,
  input  logic          rst,
  bfd_pixel_if.sink     pixel,
  bfd_result_if.source  result,
  bfd_cfg_if.sink       cfg
);

  localparam int W_W    = $clog2(MAX_WIDTH + 1);
  localparam int H_W    = bfd_pkg::H_W;
  localparam int ADDR_W = $clog2(MAX_WIDTH / FACTOR);
  localparam int CNT_W  = bfd_pkg::CNT_W;

  logic [W_W-1:0]    w, ow;
  logic [H_W-1:0]    h, oh;
  logic              accept, hit;
  bfd_pkg::pix_ctl_t ctl;
  logic [ADDR_W-1:0] addr;
  bfd_pkg::rgba_t    pix;
  logic              push;
  bfd_pkg::result_t  push_data, out_data;
  logic [1:0]        pending;
  logic [CNT_W-1:0]  count;

  assign pix         = {pixel.in_alpha, pixel.in_blue, pixel.in_green, pixel.in_red};
  assign pixel.ready = (4'(count) + 4'(pending)) < 4'(bfd_pkg::FIFO_DEPTH);
  assign accept      = pixel.valid && pixel.ready;

  bfd_config #(.FACTOR(FACTOR), .MAX_WIDTH(MAX_WIDTH)) u_config (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .w   (w),
    .h   (h),
    .ow  (ow),
    .oh  (oh)
  );

  bfd_position #(.FACTOR(FACTOR), .MAX_WIDTH(MAX_WIDTH)) u_position (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .w      (w),
    .h      (h),
    .ow     (ow),
    .oh     (oh),
    .hit    (hit),
    .ctl    (ctl),
    .addr   (addr)
  );

  bfd_accum #(.FACTOR(FACTOR), .MAX_WIDTH(MAX_WIDTH)) u_accum (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept && hit),
    .ctl       (ctl),
    .addr      (addr),
    .pix       (pix),
    .push      (push),
    .push_data (push_data),
    .pending   (pending)
  );

  bfd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (out_data),
    .count     (count)
  );

  assign result.out_red    = out_data.avg[0];
  assign result.out_green  = out_data.avg[1];
  assign result.out_blue   = out_data.avg[2];
  assign result.out_alpha  = out_data.avg[3];
  assign result.frame_last = out_data.frame_last;
  assign result.out_width  = bfd_pkg::OUT_DIM_W'(ow);
  assign result.out_height = bfd_pkg::OUT_DIM_W'(oh);

endmodule
